@@ rtl/cir_pkg.sv @@
// ----------------------------------------------------------------------------
// cir_pkg
// Shared types, constants and helpers for the contact impulse resolver.
// ----------------------------------------------------------------------------
package cir_pkg;

   localparam int NUM_BODIES_DEFAULT = 256;

   localparam int NUMW  = 54;
   localparam int DIVW  = 25;
   localparam int ITERW = 6;
   localparam int MAW   = 36;
   localparam int MBW   = 25;
   localparam int MPW   = 61;
   localparam int SW    = 51;

   localparam logic [ITERW-1:0] ITERS_SHARE   = 6'd40;
   localparam logic [ITERW-1:0] ITERS_IMPULSE = 6'd54;

   localparam logic signed [MPW-1:0] SAT_HI = 2147483647;
   localparam logic signed [MPW-1:0] SAT_LO = -SAT_HI - 1;

   typedef enum logic [1:0] {
      REQ_WRITE   = 2'd0,
      REQ_RESOLVE = 2'd1,
      REQ_READ    = 2'd2,
      REQ_NONE    = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_WRITTEN    = 3'd0,
      ST_READ       = 3'd1,
      ST_RESOLVED   = 3'd2,
      ST_SKIPPED    = 3'd3,
      ST_SEPARATING = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_WRITE, S_RD_A, S_RD_B, S_CHECK, S_DOT, S_DIV_WA, S_DIV_WB,
      S_CORR, S_IMPULSE, S_DIV_J, S_TAN, S_A_POS, S_A_VEL, S_COPY, S_B_POS,
      S_B_VEL, S_WR_A, S_WR_B, S_READ_OUT, S_RESP
   } state_type;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [23:0]      inv_mass;
      logic [16:0]      bounce;
      logic             grounded;
   } body_type;

   typedef struct packed {
      logic             start;
      logic [ITERW-1:0] iters;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [MPW-1:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7fffffff;
      end else if (v < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] clamp_n(input logic signed [31:0] v);
      logic signed [15:0] r;
      if (v > 32767) begin
         r = 16'sh7fff;
      end else if (v < -32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic [16:0] cap_bounce(input logic [16:0] v);
      return (v > 17'd65536) ? 17'd65536 : v;
   endfunction

endpackage

@@ rtl/cir_body_mem.sv @@
// ----------------------------------------------------------------------------
// cir_body_mem
// Body table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cir_body_mem #(
   parameter int DEPTH = cir_pkg::NUM_BODIES_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     waddr,
   input  cir_pkg::body_type wdata,
   input  logic [AW-1:0]     raddr,
   output cir_pkg::body_type rdata
);
   import cir_pkg::*;

   body_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ rtl/cir_mul.sv @@
// ----------------------------------------------------------------------------
// cir_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module cir_mul (
   input  logic                             clock,
   input  logic signed [cir_pkg::MAW-1:0]   a,
   input  logic signed [cir_pkg::MBW-1:0]   b,
   output logic signed [cir_pkg::MPW-1:0]   p_ff
);
   import cir_pkg::*;

   always_ff @(posedge clock) begin
      p_ff <= MPW'(a) * MPW'(b);
   end

endmodule

@@ rtl/cir_div.sv @@
// ----------------------------------------------------------------------------
// cir_div
// Restoring divider for nonnegative values, one quotient bit per cycle.
// Numerator is left-aligned; iters gives how many bits to develop.
// ----------------------------------------------------------------------------
module cir_div (
   input  logic                       clock,
   input  logic                       reset,
   input  cir_pkg::div_cmd_type       cmd,
   input  logic [cir_pkg::NUMW-1:0]   num_in,
   input  logic [cir_pkg::DIVW-1:0]   den_in,
   output cir_pkg::div_stat_type      stat,
   output logic [cir_pkg::NUMW-1:0]   quot
);
   import cir_pkg::*;

   logic [NUMW-1:0]  num_ff, q_ff;
   logic [DIVW-1:0]  rem_ff, den_ff;
   logic [ITERW-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DIVW:0]    trial;
   logic             ge;
   logic [DIVW:0]    diff;

   always_comb begin
      trial = {rem_ff, num_ff[NUMW-1]};
      ge    = trial >= {1'b0, den_ff};
      diff  = trial - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.iters;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == ITERW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         num_ff <= num_in;
         den_ff <= den_in;
         rem_ff <= '0;
         q_ff   <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUMW-2:0], 1'b0};
         rem_ff <= ge ? diff[DIVW-1:0] : trial[DIVW-1:0];
         q_ff   <= {q_ff[NUMW-2:0], ge};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = q_ff;

endmodule

@@ rtl/contact_impulse_resolver.sv @@
// ----------------------------------------------------------------------------
// contact_impulse_resolver
// Body table with write, read and impulse-based contact resolution.
// Resolves run through the sequencer, the 1-bit/cycle divider (weights for
// both bodies and, for an impulse contact, the impulse) and the shared
// multiplier. One item at a time; the next transfer is taken the cycle after
// the result is registered.
// Synchronous reset clears the sequencer and handshake; the table is not reset.
// ----------------------------------------------------------------------------
module contact_impulse_resolver #(
   parameter int NUM_BODIES = cir_pkg::NUM_BODIES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [7:0]         req_index_a,
   input  logic [7:0]         req_index_b,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic signed [31:0] req_speed_x,
   input  logic signed [31:0] req_speed_y,
   input  logic signed [31:0] req_speed_z,
   input  logic [23:0]        req_inverse_mass,
   input  logic [16:0]        req_bounce,
   input  logic [30:0]        req_penetration,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_out_pos_x,
   output logic signed [31:0] rsp_out_pos_y,
   output logic signed [31:0] rsp_out_pos_z,
   output logic signed [31:0] rsp_out_vel_x,
   output logic signed [31:0] rsp_out_vel_y,
   output logic signed [31:0] rsp_out_vel_z,
   output logic               rsp_out_grounded
);
   import cir_pkg::*;

   localparam int AW = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;

   state_type        state_ff, state_in;
   logic [1:0]       k_ff;
   logic             ph_ff;
   req_kind_type     kind_ff;
   logic [AW-1:0]    ia_ff, ib_ff;
   logic             same_ff, skip_ff;
   logic [2:0][15:0] n_ff;
   logic [30:0]      pen_ff;
   body_type         body_a_ff, body_b_ff;
   logic signed [SW-1:0] s_ff;
   logic [16:0]      wa_ff, wb_ff;
   logic [2:0][31:0] corr_ff, t_ff;
   logic [30:0]      j_ff;
   logic [NUMW-1:0]  num_ff;
   logic [DIVW-1:0]  total_ff;

   logic             rsp_valid_ff;
   logic [2:0]       rsp_status_ff;
   body_type         rsp_body_ff;

   logic [AW-1:0]    idx_lut [256];
   logic [AW-1:0]    idx_a, idx_b;
   logic             accept, impulse, last_k, mul_state, rsp_free;
   logic signed [15:0] nk, ny;
   logic signed [32:0] rel;
   logic signed [SW-1:0] vn, neg_vn;
   logic [17:0]      gain;
   logic [DIVW-1:0]  total_now;

   logic signed [MAW-1:0] mul_a;
   logic signed [MBW-1:0] mul_b;
   logic signed [MPW-1:0] prod;

   div_cmd_type      div_cmd;
   div_stat_type     div_stat;
   logic [NUMW-1:0]  div_num, quot;

   logic             mem_we;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   body_type         mem_wdata, mem_rdata, a_next;
   status_type       fin_status;

   // index wrap onto the table size
   for (genvar g = 0; g < 256; g++) begin : g_idx
      assign idx_lut[g] = AW'(g % NUM_BODIES);
   end

   cir_body_mem #(.DEPTH(NUM_BODIES), .AW(AW)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   cir_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p_ff  (prod)
   );

   cir_div u_div (
      .clock  (clock),
      .reset  (reset),
      .cmd    (div_cmd),
      .num_in (div_num),
      .den_in (total_ff),
      .stat   (div_stat),
      .quot   (quot)
   );

   always_comb begin
      idx_a     = idx_lut[req_index_a];
      idx_b     = idx_lut[req_index_b];
      accept    = req_valid && req_ready;
      impulse   = !(s_ff > 0);
      last_k    = (state_ff == S_IMPULSE) || (k_ff == 2'd2);
      mul_state = (state_ff == S_DOT) || (state_ff == S_CORR) || (state_ff == S_IMPULSE)
               || (state_ff == S_TAN) || (state_ff == S_A_POS) || (state_ff == S_A_VEL)
               || (state_ff == S_B_POS) || (state_ff == S_B_VEL);
      rsp_free  = !rsp_valid_ff || rsp_ready;
      nk        = $signed(n_ff[k_ff]);
      ny        = $signed(n_ff[1]);
      rel       = $signed({body_b_ff.vel[k_ff][31], body_b_ff.vel[k_ff]})
                - $signed({body_a_ff.vel[k_ff][31], body_a_ff.vel[k_ff]});
      vn        = s_ff >>> 14;
      neg_vn    = -vn;
      gain      = 18'd65536 + 18'(cap_bounce(body_a_ff.bounce) < cap_bounce(body_b_ff.bounce)
                  ? cap_bounce(body_a_ff.bounce) : cap_bounce(body_b_ff.bounce));
      total_now = DIVW'(body_a_ff.inv_mass) + DIVW'(mem_rdata.inv_mass);
      a_next    = body_a_ff;
      if (impulse && (ny > 16'sd8192)) begin
         a_next.grounded = 1'b1;
      end
      if (skip_ff) begin
         fin_status = ST_SKIPPED;
      end else if (impulse) begin
         fin_status = ST_RESOLVED;
      end else begin
         fin_status = ST_SEPARATING;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_kind_type'(req_type))
                  REQ_WRITE:   state_in = S_WRITE;
                  REQ_RESOLVE: state_in = S_RD_A;
                  REQ_READ:    state_in = S_RD_A;
                  REQ_NONE:    state_in = S_RESP;
                  default:     state_in = S_RESP;
               endcase
            end
         end
         S_WRITE:    state_in = S_RESP;
         S_RD_A:     state_in = (kind_ff == REQ_READ) ? S_READ_OUT : S_RD_B;
         S_READ_OUT: state_in = S_RESP;
         S_RD_B:     state_in = S_CHECK;
         S_CHECK:    state_in = (total_now == '0) ? S_RESP : S_DOT;
         S_DOT:      if (ph_ff && last_k) state_in = S_DIV_WA;
         S_DIV_WA:   if (ph_ff && div_stat.done) state_in = S_DIV_WB;
         S_DIV_WB:   if (ph_ff && div_stat.done) state_in = S_CORR;
         S_CORR:     if (ph_ff && last_k) state_in = impulse ? S_IMPULSE : S_A_POS;
         S_IMPULSE:  if (ph_ff && last_k) state_in = S_DIV_J;
         S_DIV_J:    if (ph_ff && div_stat.done) state_in = S_TAN;
         S_TAN:      if (ph_ff && last_k) state_in = S_A_POS;
         S_A_POS:    if (ph_ff && last_k) state_in = impulse ? S_A_VEL : S_COPY;
         S_A_VEL:    if (ph_ff && last_k) state_in = S_COPY;
         S_COPY:     state_in = S_B_POS;
         S_B_POS:    if (ph_ff && last_k) state_in = impulse ? S_B_VEL : S_WR_A;
         S_B_VEL:    if (ph_ff && last_k) state_in = S_WR_A;
         S_WR_A:     state_in = S_WR_B;
         S_WR_B:     state_in = S_RESP;
         S_RESP:     if (rsp_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready     = (state_ff == S_IDLE);
      mem_we        = 1'b0;
      mem_waddr     = ia_ff;
      mem_wdata     = body_a_ff;
      mem_raddr     = ia_ff;
      mul_a         = '0;
      mul_b         = '0;
      div_cmd.start = 1'b0;
      div_cmd.iters = ITERS_SHARE;
      div_num       = {body_a_ff.inv_mass, 30'b0};
      unique case (state_ff)
         S_WRITE, S_WR_A: mem_we = 1'b1;
         S_WR_B: begin
            mem_we    = 1'b1;
            mem_waddr = ib_ff;
            mem_wdata = body_b_ff;
         end
         S_RD_B: mem_raddr = ib_ff;
         S_DOT: begin
            mul_a = MAW'(rel);
            mul_b = MBW'(nk);
         end
         S_CORR: begin
            mul_a = MAW'({1'b0, pen_ff});
            mul_b = MBW'(nk);
         end
         S_IMPULSE: begin
            mul_a = neg_vn[MAW-1:0];
            mul_b = MBW'(gain);
         end
         S_TAN: begin
            mul_a = MAW'(j_ff);
            mul_b = MBW'(nk);
         end
         S_A_POS: begin
            mul_a = MAW'($signed(corr_ff[k_ff]));
            mul_b = MBW'(wa_ff);
         end
         S_B_POS: begin
            mul_a = MAW'($signed(corr_ff[k_ff]));
            mul_b = MBW'(wb_ff);
         end
         S_A_VEL: begin
            mul_a = MAW'($signed(t_ff[k_ff]));
            mul_b = MBW'(body_a_ff.inv_mass);
         end
         S_B_VEL: begin
            mul_a = MAW'($signed(t_ff[k_ff]));
            mul_b = MBW'(body_b_ff.inv_mass);
         end
         S_DIV_WA: div_cmd.start = !ph_ff;
         S_DIV_WB: begin
            div_cmd.start = !ph_ff;
            div_num       = {body_b_ff.inv_mass, 30'b0};
         end
         S_DIV_J: begin
            div_cmd.start = !ph_ff;
            div_cmd.iters = ITERS_IMPULSE;
            div_num       = num_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         ph_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (mul_state) begin
            ph_ff <= !ph_ff;
            if (ph_ff) begin
               k_ff <= last_k ? 2'd0 : k_ff + 2'd1;
            end
         end else if ((state_ff == S_DIV_WA) || (state_ff == S_DIV_WB)
                      || (state_ff == S_DIV_J)) begin
            if (!ph_ff) begin
               ph_ff <= 1'b1;
            end else if (div_stat.done) begin
               ph_ff <= 1'b0;
            end
         end else begin
            ph_ff <= 1'b0;
            k_ff  <= '0;
         end
         if ((state_ff == S_RESP) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= req_kind_type'(req_type);
         ia_ff      <= idx_a;
         ib_ff      <= idx_b;
         same_ff    <= (idx_a == idx_b);
         skip_ff    <= 1'b0;
         s_ff       <= '0;
         n_ff[0]    <= clamp_n(req_vec_x);
         n_ff[1]    <= clamp_n(req_vec_y);
         n_ff[2]    <= clamp_n(req_vec_z);
         pen_ff     <= req_penetration;
         body_a_ff.pos      <= {req_vec_z, req_vec_y, req_vec_x};
         body_a_ff.vel      <= {req_speed_z, req_speed_y, req_speed_x};
         body_a_ff.inv_mass <= req_inverse_mass;
         body_a_ff.bounce   <= req_bounce;
         body_a_ff.grounded <= 1'b0;
      end
      unique case (state_ff)
         S_RD_B, S_READ_OUT: body_a_ff <= mem_rdata;
         S_CHECK: begin
            body_b_ff <= mem_rdata;
            total_ff  <= total_now;
            skip_ff   <= (total_now == '0);
         end
         S_DOT: if (ph_ff) s_ff <= s_ff + $signed(prod[SW-1:0]);
         S_CORR: if (ph_ff) corr_ff[k_ff] <= sat32(prod >>> 14);
         S_IMPULSE: if (ph_ff) num_ff <= prod[NUMW-1:0];
         S_TAN: if (ph_ff) t_ff[k_ff] <= sat32(prod >>> 14);
         S_DIV_WA: if (ph_ff && div_stat.done) wa_ff <= quot[16:0];
         S_DIV_WB: if (ph_ff && div_stat.done) wb_ff <= quot[16:0];
         S_DIV_J: begin
            if (ph_ff && div_stat.done) begin
               j_ff <= (quot > NUMW'(31'h7fffffff)) ? 31'h7fffffff : quot[30:0];
            end
         end
         S_A_POS: begin
            if (ph_ff) begin
               body_a_ff.pos[k_ff] <=
                  sat32(MPW'($signed(body_a_ff.pos[k_ff])) - (prod >>> 16));
            end
         end
         S_B_POS: begin
            if (ph_ff) begin
               body_b_ff.pos[k_ff] <=
                  sat32(MPW'($signed(body_b_ff.pos[k_ff])) + (prod >>> 16));
            end
         end
         S_A_VEL: begin
            if (ph_ff) begin
               body_a_ff.vel[k_ff] <=
                  sat32(MPW'($signed(body_a_ff.vel[k_ff])) - (prod >>> 16));
            end
         end
         S_B_VEL: begin
            if (ph_ff) begin
               body_b_ff.vel[k_ff] <=
                  sat32(MPW'($signed(body_b_ff.vel[k_ff])) + (prod >>> 16));
            end
         end
         S_COPY: begin
            body_a_ff <= a_next;
            if (same_ff) begin
               body_b_ff <= a_next;
            end
         end
         S_WR_A: begin
            if (impulse && (ny < -16'sd8192)) begin
               body_b_ff.grounded <= 1'b1;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_body_ff <= (kind_ff == REQ_READ) ? body_a_ff : '0;
               unique case (kind_ff)
                  REQ_WRITE:   rsp_status_ff <= ST_WRITTEN;
                  REQ_RESOLVE: rsp_status_ff <= fin_status;
                  REQ_READ:    rsp_status_ff <= ST_READ;
                  REQ_NONE:    rsp_status_ff <= ST_WRITTEN;
                  default:     rsp_status_ff <= ST_WRITTEN;
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_pos_x    = rsp_body_ff.pos[0];
   assign rsp_out_pos_y    = rsp_body_ff.pos[1];
   assign rsp_out_pos_z    = rsp_body_ff.pos[2];
   assign rsp_out_vel_x    = rsp_body_ff.vel[0];
   assign rsp_out_vel_y    = rsp_body_ff.vel[1];
   assign rsp_out_vel_z    = rsp_body_ff.vel[2];
   assign rsp_out_grounded = rsp_body_ff.grounded;

`ifndef SYNTHESIS
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_stat.busy)
      else $error("divider busy while idle");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a second transfer while working");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DIV_WA || state_ff == S_DIV_WB
                         || state_ff == S_DIV_J))
      else $error("quotient finished outside a division step");
   a_mem_we: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_WRITE || state_ff == S_WR_A || state_ff == S_WR_B))
      else $error("table write outside a write step");
`endif

endmodule

@@ dv/contact_impulse_resolver_tb.sv @@
// ----------------------------------------------------------------------------
// contact_impulse_resolver_tb
// Drives body writes, reads and contact resolves into the resolver and checks
// every response against a bit-accurate fixed-point prediction of the body
// table held in a small scoreboard class.
// ----------------------------------------------------------------------------
module contact_impulse_resolver_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cir_pkg::*;

   typedef struct {
      req_kind_type       kind;
      logic [7:0]         ia;
      logic [7:0]         ib;
      logic signed [31:0] vec [3];
      logic signed [31:0] spd [3];
      logic [23:0]        inv;
      logic [16:0]        bnc;
      logic [30:0]        pen;
   } contact_req_type;

   typedef struct {
      status_type         status;
      logic signed [31:0] pos [3];
      logic signed [31:0] vel [3];
      logic               grounded;
   } body_rsp_type;

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint sat_word(longint v);
      return clip(v, -64'sd2147483648, 64'sd2147483647);
   endfunction

   class body_ledger;
      longint       pos_t [256][3];
      longint       vel_t [256][3];
      longint       inv_t [256];
      longint       bnc_t [256];
      bit           gnd_t [256];
      body_rsp_type pending [$];
      int           fails;

      function status_type resolve_contact(contact_req_type r);
         int ia, ib;
         longint inv_a, inv_b, total, wa, wb, s, vn, e, ea, eb, num, j, t;
         longint n [3], corr [3], rel [3];
         ia = r.ia; ib = r.ib;
         inv_a = inv_t[ia]; inv_b = inv_t[ib];
         total = inv_a + inv_b;
         if (total <= 0) return ST_SKIPPED;
         for (int i = 0; i < 3; i++) begin
            n[i] = clip(longint'(r.vec[i]), -32768, 32767);
            corr[i] = sat_word((n[i] * longint'(r.pen)) >>> 14);
            rel[i] = vel_t[ib][i] - vel_t[ia][i];
         end
         wa = (inv_a <<< 16) / total;
         wb = (inv_b <<< 16) / total;
         for (int i = 0; i < 3; i++) begin
            pos_t[ia][i] = sat_word(pos_t[ia][i] - ((corr[i] * wa) >>> 16));
            pos_t[ib][i] = sat_word(pos_t[ib][i] + ((corr[i] * wb) >>> 16));
         end
         s = rel[0] * n[0] + rel[1] * n[1] + rel[2] * n[2];
         if (s > 0) return ST_SEPARATING;
         vn = s >>> 14;
         ea = (bnc_t[ia] > 65536) ? 65536 : bnc_t[ia];
         eb = (bnc_t[ib] > 65536) ? 65536 : bnc_t[ib];
         e = (ea < eb) ? ea : eb;
         num = ((65536 + e) * (-vn)) / total;
         j = (num > 64'sd2147483647) ? 64'sd2147483647 : num;
         for (int i = 0; i < 3; i++) begin
            t = sat_word((j * n[i]) >>> 14);
            vel_t[ia][i] = sat_word(vel_t[ia][i] - ((t * inv_a) >>> 16));
            vel_t[ib][i] = sat_word(vel_t[ib][i] + ((t * inv_b) >>> 16));
         end
         if (n[1] < -8192) gnd_t[ib] = 1;
         if (n[1] > 8192) gnd_t[ia] = 1;
         return ST_RESOLVED;
      endfunction

      function void note_request(contact_req_type r);
         body_rsp_type x;
         x.status = ST_WRITTEN;
         x.grounded = 0;
         for (int i = 0; i < 3; i++) begin
            x.pos[i] = 0;
            x.vel[i] = 0;
         end
         case (r.kind)
            REQ_WRITE: begin
               for (int i = 0; i < 3; i++) begin
                  pos_t[r.ia][i] = longint'(r.vec[i]);
                  vel_t[r.ia][i] = longint'(r.spd[i]);
               end
               inv_t[r.ia] = longint'(r.inv);
               bnc_t[r.ia] = longint'(r.bnc);
               gnd_t[r.ia] = 0;
            end
            REQ_RESOLVE: x.status = resolve_contact(r);
            REQ_READ: begin
               x.status = ST_READ;
               for (int i = 0; i < 3; i++) begin
                  x.pos[i] = pos_t[r.ia][i][31:0];
                  x.vel[i] = vel_t[r.ia][i][31:0];
               end
               x.grounded = gnd_t[r.ia];
            end
            default: ;
         endcase
         pending = {pending, x};
      endfunction

      function void check_response(body_rsp_type a);
         body_rsp_type x;
         if (pending.size() == 0) begin
            $error("response with none outstanding");
            fails++;
            return;
         end
         x = pending.pop_front();
         if (a.status !== x.status) begin
            $error("status exp %0d got %0d", x.status, a.status); fails++;
         end
         for (int i = 0; i < 3; i++) begin
            if (a.pos[i] !== x.pos[i]) begin
               $error("out_pos[%0d] exp %0d got %0d", i, x.pos[i], a.pos[i]); fails++;
            end
            if (a.vel[i] !== x.vel[i]) begin
               $error("out_vel[%0d] exp %0d got %0d", i, x.vel[i], a.vel[i]); fails++;
            end
         end
         if (a.grounded !== x.grounded) begin
            $error("out_grounded exp %0d got %0d", x.grounded, a.grounded); fails++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [1:0]         req_type = 0;
   logic [7:0]         req_index_a = 0, req_index_b = 0;
   logic signed [31:0] req_vec_x = 0, req_vec_y = 0, req_vec_z = 0;
   logic signed [31:0] req_speed_x = 0, req_speed_y = 0, req_speed_z = 0;
   logic [23:0]        req_inverse_mass = 0;
   logic [16:0]        req_bounce = 0;
   logic [30:0]        req_penetration = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_out_pos_x, rsp_out_pos_y, rsp_out_pos_z;
   logic signed [31:0] rsp_out_vel_x, rsp_out_vel_y, rsp_out_vel_z;
   logic               rsp_out_grounded;

   contact_impulse_resolver u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   body_ledger ledger = new();
   bit         written [256];
   bit         calm = 0;
   bit         hold_req = 0;
   int         idle_cycles = 0;

   always @(posedge clock) begin
      body_rsp_type a;
      if (!reset && rsp_valid && rsp_ready) begin
         a.status = status_type'(rsp_status);
         a.pos[0] = rsp_out_pos_x; a.pos[1] = rsp_out_pos_y; a.pos[2] = rsp_out_pos_z;
         a.vel[0] = rsp_out_vel_x; a.vel[1] = rsp_out_vel_y; a.vel[2] = rsp_out_vel_z;
         a.grounded = rsp_out_grounded;
         ledger.check_response(a);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_ready <= 0;
            repeat (400) @(posedge clock);
            hold_req = 0;
         end else begin
            rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 16);
         end
      end
   end

   // stall watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 5000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_req(contact_req_type r);
      if (!calm && $urandom_range(0, 99) < 16) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid        <= 1;
      req_type         <= r.kind;
      req_index_a      <= r.ia;
      req_index_b      <= r.ib;
      req_vec_x        <= r.vec[0];
      req_vec_y        <= r.vec[1];
      req_vec_z        <= r.vec[2];
      req_speed_x      <= r.spd[0];
      req_speed_y      <= r.spd[1];
      req_speed_z      <= r.spd[2];
      req_inverse_mass <= r.inv;
      req_bounce       <= r.bnc;
      req_penetration  <= r.pen;
      do @(posedge clock); while (!req_ready);
      ledger.note_request(r);
      if (r.kind == REQ_WRITE) written[r.ia] = 1;
   endtask

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 131072) - 65536;
         1: return 32'sh7fffffff - $urandom_range(0, 3);
         2: return 32'sh80000000 + $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic contact_req_type blank_req(req_kind_type k, int a, int b);
      contact_req_type r;
      r.kind = k; r.ia = 8'(a); r.ib = 8'(b);
      for (int i = 0; i < 3; i++) begin
         r.vec[i] = 0;
         r.spd[i] = 0;
      end
      r.inv = 0; r.bnc = 0; r.pen = 0;
      return r;
   endfunction

   function automatic contact_req_type body_req(int a, int inv);
      contact_req_type r;
      r = blank_req(REQ_WRITE, a, 0);
      for (int i = 0; i < 3; i++) begin
         r.vec[i] = rand_word();
         r.spd[i] = rand_word();
      end
      r.inv = 24'(inv);
      r.bnc = 17'($urandom_range(0, 65536));
      return r;
   endfunction

   function automatic int pick_index();
      return ($urandom_range(0, 99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, 255);
   endfunction

   function automatic contact_req_type random_req();
      contact_req_type r;
      int a, b, p;
      int inv;
      a = pick_index();
      b = ($urandom_range(0, 9) == 0) ? a : pick_index();
      p = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
         0: inv = 0;
         1: inv = $urandom_range(1, 131072);
         2: inv = 24'hffffff - $urandom_range(0, 3);
         default: inv = $urandom_range(0, 24'hffffff);
      endcase
      if (!written[a] || p < 30) return body_req(a, inv);
      if (p < 75 && written[b]) begin
         r = blank_req(REQ_RESOLVE, a, b);
         for (int i = 0; i < 3; i++)
            r.vec[i] = ($urandom_range(0, 9) == 0) ? $urandom
                                                   : $urandom_range(0, 65535) - 32768;
         r.pen = ($urandom_range(0, 4) == 0) ? 31'($urandom)
                                             : 31'($urandom_range(0, 262144));
         return r;
      end
      r = blank_req((p < 95) ? REQ_READ : REQ_NONE, a, b);
      if (r.kind == REQ_NONE) begin
         for (int i = 0; i < 3; i++) begin
            r.vec[i] = $urandom;
            r.spd[i] = $urandom;
         end
         r.inv = 24'($urandom); r.bnc = 17'($urandom); r.pen = 31'($urandom);
      end
      return r;
   endfunction

   initial begin
      contact_req_type r;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed
      r = blank_req(REQ_WRITE, 0, 0);
      r.vec[0] = 32'sh7fffffff; r.vec[1] = 32'sh80000000; r.vec[2] = -1;
      r.spd[0] = 32'sh80000000; r.spd[1] = 32'sh7fffffff; r.spd[2] = 0;
      r.inv = 24'hffffff; r.bnc = 17'd65536;
      send_req(r);
      r = blank_req(REQ_WRITE, 255, 0);
      r.spd[0] = 32'sh7fffffff; r.spd[1] = 32'sh80000000; r.spd[2] = 65536;
      r.inv = 24'hffffff; r.bnc = 0;
      send_req(r);
      send_req(blank_req(REQ_WRITE, 1, 0));
      send_req(blank_req(REQ_WRITE, 2, 0));
      send_req(blank_req(REQ_READ, 0, 0));
      send_req(blank_req(REQ_READ, 255, 0));
      r = blank_req(REQ_RESOLVE, 1, 2);
      r.vec[1] = 16384; r.pen = 65536;
      send_req(r);
      r = blank_req(REQ_NONE, 3, 4);
      r.vec[0] = -1; r.inv = 24'hffffff; r.bnc = 17'h1ffff; r.pen = 31'h7fffffff;
      send_req(r);
      r = blank_req(REQ_RESOLVE, 0, 255);
      r.vec[0] = 32'sh7fffffff; r.vec[1] = -16384; r.vec[2] = 32'sh80000000;
      r.pen = 31'h7fffffff;
      send_req(r);
      r.vec[0] = -16384; r.vec[1] = 16384; r.vec[2] = 0; r.pen = 0;
      send_req(r);
      r = blank_req(REQ_RESOLVE, 255, 0);
      r.vec[0] = 16384; r.pen = 4096;
      send_req(r);
      r = blank_req(REQ_RESOLVE, 0, 0);
      r.vec[1] = 16384; r.pen = 32768;
      send_req(r);
      send_req(blank_req(REQ_READ, 0, 0));
      send_req(blank_req(REQ_READ, 255, 0));
      r = body_req(3, 65536); r.spd[0] = 65536 * 4; send_req(r);
      r = body_req(4, 65536); r.spd[0] = 0; send_req(r);
      r = blank_req(REQ_RESOLVE, 3, 4);
      r.vec[0] = 16384; r.pen = 1000;
      send_req(r);
      send_req(blank_req(REQ_READ, 3, 0));
      send_req(blank_req(REQ_READ, 4, 0));
      send_req(blank_req(REQ_READ, 1, 0));
      send_req(blank_req(REQ_READ, 2, 0));

      for (int k = 0; k < 1950; k++) begin
         calm = (k >= 600 && k < 850);
         if (k == 1200) hold_req = 1;
         send_req(random_req());
      end
      req_valid <= 0;

      while (ledger.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (ledger.fails == 0 && ledger.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
